[rtl/core/sedh_pkg.sv]
// ----------------------------------------------------------------------------
// sedh_pkg
// shared types, constants and the per-channel error diffusion arithmetic
// ----------------------------------------------------------------------------
package sedh_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_CHANNELS  = 3;
   localparam int ERR_W         = 14;
   localparam int WIDE_W        = 18;
   localparam int ROW_W         = 12;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [7:0]  DEF_THRESHOLD    = 8'd128;
   localparam logic [10:0] DEF_FRAME_WIDTH  = 11'd500;
   localparam logic [11:0] DEF_FRAME_HEIGHT = 12'd375;
   localparam logic        DEF_INVERT_MODE  = 1'b1;

   localparam logic [7:0] DOT_ON  = 8'hFF;
   localparam logic [7:0] DOT_OFF = 8'h00;

   localparam logic signed [WIDE_W-1:0] WIDE_ERR_MAX = 18'sd8191;
   localparam logic signed [WIDE_W-1:0] WIDE_ERR_MIN = -18'sd8192;
   localparam logic signed [WIDE_W-1:0] FULL_SCALE   = 18'sd4080;

   typedef enum logic [1:0] {
      REG_THRESHOLD    = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2,
      REG_INVERT_MODE  = 2'd3
   } reg_index_type;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef struct packed {
      logic [7:0]  threshold;
      logic [10:0] frame_width;
      logic [11:0] frame_height;
      logic        invert_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0] chan_a;
      logic [7:0] chan_b;
      logic [7:0] chan_c;
   } req_type;

   typedef struct packed {
      logic [7:0] dot_a;
      logic [7:0] dot_b;
      logic [7:0] dot_c;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic interior;
      logic wr_en;
      logic row_end;
      logic row_start;
      logic frame_start;
      logic frame_end;
   } flags_type;

   typedef struct packed {
      logic    hit;
      err_type carry;
      err_type below;
      err_type pend_left;
      err_type pend_here;
   } chan_result_type;

   function automatic err_type sat_err(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_ERR_MAX) begin
         return ERR_W'(WIDE_ERR_MAX);
      end
      if (v < WIDE_ERR_MIN) begin
         return ERR_W'(WIDE_ERR_MIN);
      end
      return ERR_W'(v);
   endfunction

   function automatic chan_result_type diffuse_chan(
      input logic [7:0] sample,
      input logic       invert,
      input logic [7:0] level,
      input err_type    stored,
      input err_type    carry,
      input err_type    pend_left,
      input err_type    pend_here
   );
      logic [7:0]               s_eff;
      err_type                  err;
      logic signed [WIDE_W-1:0] f;
      logic signed [WIDE_W-1:0] lim;
      logic signed [WIDE_W-1:0] d;
      logic signed [WIDE_W-1:0] d3;
      logic signed [WIDE_W-1:0] d5;
      logic signed [WIDE_W-1:0] d7;
      chan_result_type          res;
      s_eff         = sample ^ {8{invert}};
      err           = sat_err(WIDE_W'(stored) + WIDE_W'(carry));
      f             = $signed({6'b0, s_eff, 4'b0}) + WIDE_W'(err);
      lim           = $signed({6'b0, level, 4'b0});
      res.hit       = (f > lim);
      d             = res.hit ? (f - FULL_SCALE) : f;
      d3            = (d <<< 1) + d;
      d5            = (d <<< 2) + d;
      d7            = (d <<< 3) - d;
      res.carry     = ERR_W'(d7 >>> 4);
      res.below     = sat_err(WIDE_W'(pend_left) + (d3 >>> 4));
      res.pend_left = sat_err(WIDE_W'(pend_here) + (d5 >>> 4));
      res.pend_here = ERR_W'(d >>> 4);
      return res;
   endfunction

endpackage

[rtl/core/sedh_csr.sv]
// ----------------------------------------------------------------------------
// sedh_csr
// apb register file: threshold, frame size and cmy inversion
// ----------------------------------------------------------------------------
module sedh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sedh_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sedh_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sedh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output sedh_pkg::cfg_type                   cfg
);
   import sedh_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_fire;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (index)
            REG_THRESHOLD:    cfg_in.threshold    = csr_pwdata[7:0];
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[10:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[11:0];
            REG_INVERT_MODE:  cfg_in.invert_mode  = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_THRESHOLD:    csr_prdata = {24'b0, cfg_ff.threshold};
         REG_FRAME_WIDTH:  csr_prdata = {21'b0, cfg_ff.frame_width};
         REG_FRAME_HEIGHT: csr_prdata = {20'b0, cfg_ff.frame_height};
         REG_INVERT_MODE:  csr_prdata = {31'b0, cfg_ff.invert_mode};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= DEF_THRESHOLD;
         cfg_ff.frame_width  <= DEF_FRAME_WIDTH;
         cfg_ff.frame_height <= DEF_FRAME_HEIGHT;
         cfg_ff.invert_mode  <= DEF_INVERT_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/sedh_raster.sv]
// ----------------------------------------------------------------------------
// sedh_raster
// raster position counters and per-pixel border and line-store flags
// ----------------------------------------------------------------------------
module sedh_raster #(
   parameter int MAX_WIDTH = sedh_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sedh_pkg::cfg_type            cfg,
   input  logic                         accept,
   output sedh_pkg::flags_type          flags,
   output logic [$clog2(MAX_WIDTH)-1:0] col,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_addr
);
   import sedh_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
   localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [WW-1:0]    w_raw;
   logic [WW-1:0]    w_eff;
   logic [WW-1:0]    col_ext;
   logic [WW-1:0]    tail_addr;
   logic [ROW_W-1:0] h_eff;
   logic [ROW_W:0]   row_ext;
   logic             inner_row;

   assign w_raw   = WW'(cfg.frame_width);
   assign w_eff   = (w_raw < WW'(3)) ? WW'(3) : ((w_raw > MAXW) ? MAXW : w_raw);
   assign h_eff   = (cfg.frame_height < ROW_W'(3)) ? ROW_W'(3) : cfg.frame_height;
   assign col_ext = WW'(col_ff);
   assign row_ext = {1'b0, row_ff};

   assign tail_addr = w_eff - WW'(2);

   always_comb begin
      flags.row_end     = (col_ext + WW'(1)) >= w_eff;
      flags.frame_end   = flags.row_end && ((row_ext + (ROW_W+1)'(1)) >= {1'b0, h_eff});
      inner_row         = (row_ff != '0) && ((row_ext + (ROW_W+1)'(2)) <= {1'b0, h_eff});
      flags.interior    = inner_row && (col_ff != '0) && ((col_ext + WW'(2)) <= w_eff);
      flags.wr_en       = (flags.interior && (col_ff >= CW'(2))) ||
                          (inner_row && flags.row_end);
      flags.row_start   = (col_ff == '0);
      flags.frame_start = (col_ff == '0) && (row_ff == '0);
   end

   assign col     = col_ff;
   assign wr_addr = flags.interior ? (col_ff - CW'(1)) : tail_addr[CW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.row_end) begin
            col_in = '0;
            row_in = flags.frame_end ? '0 : (row_ff + ROW_W'(1));
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && flags.row_end |=> col_ff == '0)
      else $error("column did not wrap after end of row");
`endif

endmodule

[rtl/core/sedh_diffuse.sv]
// ----------------------------------------------------------------------------
// sedh_diffuse
// error line store, diffusion stage and neighbour error registers
// ----------------------------------------------------------------------------
module sedh_diffuse #(
   parameter int MAX_WIDTH = sedh_pkg::DEF_MAX_WIDTH,
   parameter int CHANNELS  = sedh_pkg::DEF_CHANNELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sedh_pkg::cfg_type            cfg,
   input  logic                         accept,
   input  sedh_pkg::req_type            pix,
   input  sedh_pkg::flags_type          flags,
   input  logic [$clog2(MAX_WIDTH)-1:0] col,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic                         s1_adv,
   output logic                         s1_valid,
   output sedh_pkg::rsp_type            result
);
   import sedh_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = CHANNELS * ERR_W;

   logic [LW-1:0]   line_mem [MAX_WIDTH];
   logic [LW-1:0]   rd_word_ff;
   logic [LW-1:0]   wr_word;
   logic            wr_fire;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_type         s1_pix_ff;
   flags_type       s1_flags_ff;
   logic [CW-1:0]   s1_col_ff;
   logic [CW-1:0]   s1_wr_addr_ff;

   err_type         rc_ff [CHANNELS];
   err_type         rc_in [CHANNELS];
   err_type         pl_ff [CHANNELS];
   err_type         pl_in [CHANNELS];
   err_type         ph_ff [CHANNELS];
   err_type         ph_in [CHANNELS];
   logic [CW-1:0]   fill_ff;
   logic [CW-1:0]   fill_in;

   logic            line_ok;
   logic [7:0]      samples [3];
   logic [7:0]      dots [3];
   chan_result_type res [CHANNELS];

   assign wr_fire  = s1_adv && s1_flags_ff.wr_en;
   assign line_ok  = (s1_col_ff <= fill_ff);
   assign s1_valid = s1_valid_ff;

   assign samples[0] = s1_pix_ff.chan_a;
   assign samples[1] = s1_pix_ff.chan_b;
   assign samples[2] = s1_pix_ff.chan_c;

   always_comb begin
      err_type stored;
      wr_word = '0;
      for (int c = 0; c < 3; c++) begin
         dots[c] = DOT_OFF;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         stored = line_ok ? err_type'(rd_word_ff[c*ERR_W +: ERR_W]) : '0;
         res[c] = diffuse_chan(samples[c], cfg.invert_mode, cfg.threshold,
                               stored, rc_ff[c], pl_ff[c], ph_ff[c]);
         wr_word[c*ERR_W +: ERR_W] = s1_flags_ff.interior ? res[c].below : pl_ff[c];
         dots[c] = ((s1_flags_ff.interior && res[c].hit) ? DOT_ON : DOT_OFF) ^
                   {8{cfg.invert_mode}};
      end
   end

   always_comb begin
      result.dot_a     = dots[0];
      result.dot_b     = dots[1];
      result.dot_c     = dots[2];
      result.frame_end = s1_flags_ff.frame_end;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         rc_in[c] = rc_ff[c];
         pl_in[c] = pl_ff[c];
         ph_in[c] = ph_ff[c];
      end
      if (s1_adv) begin
         if (s1_flags_ff.frame_start) begin
            fill_in = '0;
         end else if (s1_flags_ff.wr_en && (s1_wr_addr_ff > fill_ff)) begin
            fill_in = s1_wr_addr_ff;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            if (s1_flags_ff.row_start) begin
               rc_in[c] = '0;
               pl_in[c] = '0;
               ph_in[c] = '0;
            end else if (s1_flags_ff.interior) begin
               rc_in[c] = res[c].carry;
               pl_in[c] = res[c].pend_left;
               ph_in[c] = res[c].pend_here;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         line_mem[s1_wr_addr_ff] <= wr_word;
      end
      if (accept) begin
         rd_word_ff <= line_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= pix;
         s1_flags_ff   <= flags;
         s1_col_ff     <= col;
         s1_wr_addr_ff <= wr_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fill_ff     <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            rc_ff[c] <= '0;
            pl_ff[c] <= '0;
            ph_ff[c] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         fill_ff     <= fill_in;
         for (int c = 0; c < CHANNELS; c++) begin
            rc_ff[c] <= rc_in[c];
            pl_ff[c] <= pl_in[c];
            ph_ff[c] <= ph_in[c];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      wr_fire && accept |-> s1_wr_addr_ff != col)
      else $error("line store read and write hit the same entry");

   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_flags_ff.frame_start |=> fill_ff == '0)
      else $error("fill count not cleared at frame start");
`endif

endmodule

[rtl/core/separable_error_diffusion_halftone_top.sv]
// ----------------------------------------------------------------------------
// separable_error_diffusion_halftone_top
// floyd-steinberg error diffusion halftoner, three channels, raster order
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, left to right on every
// row, one transaction per pixel; halftoned dots leave on the rsp_ channel
// in the same order, one transaction per pixel, frame_end set on the last.
// Both channels use valid/ready. Throughput is one pixel per clock unless the
// receiver stalls: the error carried to the right neighbour feeds back from
// the diffusion stage registers, and the line store does one read and one
// write per cycle. A pixel passes the line store read and diffusion stage
// register, then the output register. When the receiver stalls, the output
// register and the diffusion stage hold and req_ready drops once both are
// full. Reset clears the raster position and the carried errors and loads
// the default registers. The line store needs no clearing pass: a fill count,
// cleared on the first pixel of each frame, marks entries not yet written in
// the frame and those read as zero. Registers must be written over the csr_
// apb port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module separable_error_diffusion_halftone_top #(
   parameter int MAX_WIDTH = sedh_pkg::DEF_MAX_WIDTH,
   parameter int CHANNELS  = sedh_pkg::DEF_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sedh_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sedh_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sedh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sedh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sedh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import sedh_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   cfg_type       cfg;
   flags_type     flags;
   logic [CW-1:0] col;
   logic [CW-1:0] wr_addr;
   logic          accept;
   logic          s1_valid;
   logic          s1_adv;
   logic          out_free;
   rsp_type       result;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid && out_free;
   assign req_ready = !s1_valid || out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sedh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sedh_raster #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .flags   (flags),
      .col     (col),
      .wr_addr (wr_addr)
   );

   sedh_diffuse #(
      .MAX_WIDTH (MAX_WIDTH),
      .CHANNELS  (CHANNELS)
   ) u_diffuse (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .pix      (req_data),
      .flags    (flags),
      .col      (col),
      .wr_addr  (wr_addr),
      .s1_adv   (s1_adv),
      .s1_valid (s1_valid),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_enter_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid)
      else $error("accepted transaction missing from diffusion stage");
`endif

endmodule
